// ===== sv/gcd_pkg.sv =====
package gcd_pkg;

  // Fixed-point format of every angle and every trigonometric value.
  localparam int FRAC_BITS    = 29;
  // Rotations per CORDIC pass. ATAN_TAB below holds one entry per rotation.
  localparam int CORDIC_STEPS = 30;

  // Width of the datapath words inside the sine/cosine CORDIC.
  localparam int ANGLE_W = 32;
  // Width of a square-root result and of its radicand before scaling.
  localparam int ROOT_W  = FRAC_BITS + 1;

  // Angle constants with FRAC_BITS fraction bits; HALF_PI is truncated, the others rounded.
  localparam logic signed [33:0] PI_F    = 34'sd1686629713;
  localparam logic signed [33:0] TWO_PI  = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI = 34'sd843314856;

  // Reciprocal of the CORDIC gain over CORDIC_STEPS rotations; the start x of every sine/cosine pass.
  localparam logic signed [ANGLE_W-1:0] GAIN = 32'sd326016437;

  // One in the fixed-point format.
  localparam logic [ROOT_W-1:0] ONE_F = ROOT_W'(1) << FRAC_BITS;

  // atan(2^-i), rounded to FRAC_BITS fraction bits.
  localparam logic signed [ANGLE_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
    32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
    32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
    32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384,
    32'sd8192,      32'sd4096,      32'sd2048,      32'sd1024,
    32'sd512,       32'sd256,       32'sd128,       32'sd64,
    32'sd32,        32'sd16,        32'sd8,         32'sd4,
    32'sd2,         32'sd1
  };

  // Pipeline depths.
  localparam int SINCOS_LAT = CORDIC_STEPS + 3;
  localparam int SQRT_LAT   = ROOT_W;
  localparam int PIPE_DEPTH = 1 + SINCOS_LAT + 3 + SQRT_LAT + CORDIC_STEPS + 1;

endpackage

// ===== sv/gcd_sincos.sv =====
// Sine and cosine of one angle per cycle while en_i is high: range reduction,
// quadrant fold, one rotation per stage, and a magnitude/sign output stage.
module gcd_sincos (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [gcd_pkg::ANGLE_W-1:0]  angle_i,
  output logic        [gcd_pkg::ANGLE_W-1:0]  sin_mag_o,
  output logic        [gcd_pkg::ANGLE_W-1:0]  cos_mag_o,
  output logic                                cos_neg_o
);

  localparam int W = gcd_pkg::ANGLE_W;
  localparam int S = gcd_pkg::CORDIC_STEPS;

  logic signed [33:0]  red_d;
  logic signed [W-1:0] red_q;
  logic signed [33:0]  fold_d;
  logic                flip_d;
  logic signed [W-1:0] z0_q;
  logic                flip0_q;

  logic signed [W-1:0] x_q    [S];
  logic signed [W-1:0] y_q    [S];
  logic signed [W-1:0] z_q    [S];
  logic                flip_q [S];

  logic [W-1:0] sin_mag_q;
  logic [W-1:0] cos_mag_q;
  logic         cos_neg_q;

  // Reduce into (-pi, pi] with one correction of two pi.
  always_comb begin
    logic signed [33:0] a;
    a = 34'(angle_i);
    if (a > gcd_pkg::PI_F) begin
      red_d = a - gcd_pkg::TWO_PI;
    end else if (a <= -gcd_pkg::PI_F) begin
      red_d = a + gcd_pkg::TWO_PI;
    end else begin
      red_d = a;
    end
  end

  // Fold into [-pi/2, pi/2]; a fold negates the cosine.
  always_comb begin
    logic signed [33:0] r;
    r = 34'(red_q);
    flip_d = 1'b1;
    if (r > gcd_pkg::HALF_PI) begin
      fold_d = gcd_pkg::PI_F - r;
    end else if (r < -gcd_pkg::HALF_PI) begin
      fold_d = -gcd_pkg::PI_F - r;
    end else begin
      fold_d = r;
      flip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= red_d[W-1:0];
      z0_q    <= fold_d[W-1:0];
      flip0_q <= flip_d;
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_rot
    logic signed [W-1:0] xi, yi, zi;
    logic                fi;
    if (i == 0) begin : g_first
      assign xi = gcd_pkg::GAIN;
      assign yi = '0;
      assign zi = z0_q;
      assign fi = flip0_q;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign fi = flip_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (zi >= 0) begin
          x_q[i] <= xi - (yi >>> i);
          y_q[i] <= yi + (xi >>> i);
          z_q[i] <= zi - gcd_pkg::ATAN_TAB[i];
        end else begin
          x_q[i] <= xi + (yi >>> i);
          y_q[i] <= yi - (xi >>> i);
          z_q[i] <= zi + gcd_pkg::ATAN_TAB[i];
        end
        flip_q[i] <= fi;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_mag_q <= (y_q[S-1] < 0) ? W'(-y_q[S-1]) : W'(y_q[S-1]);
      cos_mag_q <= (x_q[S-1] < 0) ? W'(-x_q[S-1]) : W'(x_q[S-1]);
      cos_neg_q <= flip_q[S-1] ? (x_q[S-1] > 0) : (x_q[S-1] < 0);
    end
  end

  assign sin_mag_o = sin_mag_q;
  assign cos_mag_o = cos_mag_q;
  assign cos_neg_o = cos_neg_q;

endmodule

// ===== sv/gcd_sqrt.sv =====
// Pipelined square root floor(sqrt(rad * 2^FRAC_BITS)), one root bit per stage.
module gcd_sqrt (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [gcd_pkg::ROOT_W-1:0]        rad_i,
  output logic [gcd_pkg::ROOT_W-1:0]        root_o
);

  localparam int B  = gcd_pkg::ROOT_W;
  localparam int RW = 2 * gcd_pkg::FRAC_BITS + 1;

  logic [RW-1:0] rem_q  [B];
  logic [B-1:0]  root_q [B];

  for (genvar k = 0; k < B; k++) begin : g_bit
    localparam int Bit = B - 1 - k;
    logic [RW-1:0] rem_in;
    logic [B-1:0]  root_in;
    logic [RW:0]   trial;
    if (k == 0) begin : g_first
      assign rem_in  = RW'(rad_i) << gcd_pkg::FRAC_BITS;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end
    // (root + 2^b)^2 - root^2 with the low bits of root still clear.
    assign trial = ((RW+1)'(root_in) << (Bit + 1)) + ((RW+1)'(1) << (2 * Bit));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ((RW+1)'(rem_in) >= trial) begin
          rem_q[k]  <= rem_in - trial[RW-1:0];
          root_q[k] <= root_in | (B'(1) << Bit);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[B-1];

endmodule

// ===== sv/great_circle_distance_unit.sv =====
// Throughput: one point pair per cycle; every stage of the 98-stage pipeline takes
// a new beat each cycle while the output side keeps up.
// A result that is not taken parks in a one-beat skid register; the pipeline
// stalls only while that register is full.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload is not reset.
module great_circle_distance_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [30:0] lat_first_i,
  input  logic signed [31:0] lon_first_i,
  input  logic signed [30:0] lat_second_i,
  input  logic signed [31:0] lon_second_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [30:0] central_angle_o
);

  localparam int W     = gcd_pkg::ANGLE_W;
  localparam int S     = gcd_pkg::CORDIC_STEPS;
  localparam int F     = gcd_pkg::FRAC_BITS;
  localparam int RTW   = gcd_pkg::ROOT_W;
  localparam int D     = gcd_pkg::PIPE_DEPTH;
  localparam int VW    = RTW + 3;

  // The whole pipeline moves together; it holds only while the skid is full.
  logic en;
  logic [D-1:0] vld_q;

  // ---------------------------------------------------------------------------
  // Input stage: register the latitudes and the half differences. The halving
  // is an arithmetic shift, so it rounds toward minus infinity.
  // ---------------------------------------------------------------------------
  logic signed [30:0] lat1_q, lat2_q, dlat_q;
  logic signed [31:0] dlon_q;
  logic signed [31:0] dlat_full;
  logic signed [32:0] dlon_full;

  assign dlat_full = 32'(lat_first_i) - 32'(lat_second_i);
  assign dlon_full = 33'(lon_first_i) - 33'(lon_second_i);

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat1_q <= lat_first_i;
      lat2_q <= lat_second_i;
      dlat_q <= $signed(dlat_full[31:1]);
      dlon_q <= $signed(dlon_full[32:1]);
    end
  end

  // ---------------------------------------------------------------------------
  // Four sine/cosine pipelines run side by side. Only the sines of the half
  // differences and the cosines of the two latitudes are used.
  // ---------------------------------------------------------------------------
  logic [W-1:0] sa_mag, sb_mag, c1_mag, c2_mag;
  logic [W-1:0] sa_cos_unused, sb_cos_unused, c1_sin_unused, c2_sin_unused;
  logic         sa_neg_unused, sb_neg_unused, c1_neg, c2_neg;

  gcd_sincos u_sc_dlat (
    .clk_i, .en_i(en), .angle_i(W'(dlat_q)),
    .sin_mag_o(sa_mag), .cos_mag_o(sa_cos_unused), .cos_neg_o(sa_neg_unused)
  );
  gcd_sincos u_sc_dlon (
    .clk_i, .en_i(en), .angle_i(dlon_q),
    .sin_mag_o(sb_mag), .cos_mag_o(sb_cos_unused), .cos_neg_o(sb_neg_unused)
  );
  gcd_sincos u_sc_lat1 (
    .clk_i, .en_i(en), .angle_i(W'(lat1_q)),
    .sin_mag_o(c1_sin_unused), .cos_mag_o(c1_mag), .cos_neg_o(c1_neg)
  );
  gcd_sincos u_sc_lat2 (
    .clk_i, .en_i(en), .angle_i(W'(lat2_q)),
    .sin_mag_o(c2_sin_unused), .cos_mag_o(c2_mag), .cos_neg_o(c2_neg)
  );

  // ---------------------------------------------------------------------------
  // Haversine term h = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2).
  // Products truncate the magnitude and then take the sign. The squares and
  // the cosine product are formed first, then the second product, then
  // the sum with its clamp to [0, 1].
  // ---------------------------------------------------------------------------
  logic [63:0] prod_sa, prod_sb, prod_c, prod_q;
  logic [W-1:0] sa2_q, sb2_q, p12_mag_q, sa2_b_q, q_mag_q;
  logic         p12_neg_q, q_neg_q;

  assign prod_sa = 64'(sa_mag) * 64'(sa_mag);
  assign prod_sb = 64'(sb_mag) * 64'(sb_mag);
  assign prod_c  = 64'(c1_mag) * 64'(c2_mag);
  assign prod_q  = 64'(p12_mag_q) * 64'(sb2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa2_q     <= prod_sa[F +: W];
      sb2_q     <= prod_sb[F +: W];
      p12_mag_q <= prod_c[F +: W];
      p12_neg_q <= c1_neg ^ c2_neg;
      sa2_b_q   <= sa2_q;
      q_mag_q   <= prod_q[F +: W];
      q_neg_q   <= p12_neg_q;
    end
  end

  logic signed [W+2:0] h_sum;
  logic [RTW-1:0]      h_d, h_q, omh_q;

  always_comb begin
    logic signed [W+2:0] term;
    term  = $signed({3'b000, q_mag_q});
    h_sum = $signed({3'b000, sa2_b_q}) + (q_neg_q ? -term : term);
    if (h_sum < 0) begin
      h_d = '0;
    end else if (h_sum > $signed((W+3)'(gcd_pkg::ONE_F))) begin
      h_d = gcd_pkg::ONE_F;
    end else begin
      h_d = h_sum[RTW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q   <= h_d;
      omh_q <= gcd_pkg::ONE_F - h_d;
    end
  end

  // ---------------------------------------------------------------------------
  // sqrt(h) and sqrt(1 - h), one root bit per stage.
  // ---------------------------------------------------------------------------
  logic [RTW-1:0] root_h, root_omh;

  gcd_sqrt u_sqrt_h   (.clk_i, .en_i(en), .rad_i(h_q),   .root_o(root_h));
  gcd_sqrt u_sqrt_omh (.clk_i, .en_i(en), .rad_i(omh_q), .root_o(root_omh));

  // ---------------------------------------------------------------------------
  // Arcsine as atan2(sqrt(h), sqrt(1 - h)) by a vectoring CORDIC, one
  // rotation per stage.
  // ---------------------------------------------------------------------------
  logic signed [VW-1:0] vx_q [S];
  logic signed [VW-1:0] vy_q [S];
  logic signed [W-1:0]  vz_q [S];

  for (genvar i = 0; i < S; i++) begin : g_vec
    logic signed [VW-1:0] xi, yi;
    logic signed [W-1:0]  zi;
    if (i == 0) begin : g_first
      assign xi = $signed({3'b000, root_omh});
      assign yi = $signed({3'b000, root_h});
      assign zi = '0;
    end else begin : g_next
      assign xi = vx_q[i-1];
      assign yi = vy_q[i-1];
      assign zi = vz_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (yi >= 0) begin
          vx_q[i] <= xi + (yi >>> i);
          vy_q[i] <= yi - (xi >>> i);
          vz_q[i] <= zi + gcd_pkg::ATAN_TAB[i];
        end else begin
          vx_q[i] <= xi - (yi >>> i);
          vy_q[i] <= yi + (xi >>> i);
          vz_q[i] <= zi - gcd_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  // Final stage: clamp the accumulated angle at zero, double it, and saturate at pi.
  logic signed [33:0] ang2;
  logic [30:0]        res_d, res_q;

  always_comb begin
    ang2 = (vz_q[S-1] < 0) ? '0 : (34'(vz_q[S-1]) <<< 1);
    if (ang2 > gcd_pkg::PI_F) begin
      res_d = gcd_pkg::PI_F[30:0];
    end else begin
      res_d = ang2[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits travel beside the data, one per stage.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[D-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid register. The last stage hands its beat over
  // whenever the pipeline moves; if the output register is still occupied,
  // the beat waits in the skid register and the pipeline holds.
  // ---------------------------------------------------------------------------
  logic        out_valid_q, skid_valid_q;
  logic [30:0] out_q, skid_q;

  assign en = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (vld_q[D-1]) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (vld_q[D-1]) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= res_q;
      end else begin
        out_q <= res_q;
      end
    end
  end

  assign in_ready_o      = en;
  assign out_valid_o     = out_valid_q;
  assign central_angle_o = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a beat while the output register is empty");

  a_skid_catches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && !skid_valid_q && vld_q[D-1]) |=> skid_valid_q)
    else $error("finished beat was not parked while the output stalled");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (!skid_valid_q && out_valid_q))
    else $error("skid register did not move into the output register");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({3'b000, out_q} <= gcd_pkg::PI_F))
    else $error("central angle above pi");

endmodule
